// ----- src/bl_pkg.sv -----
package bl_pkg;

    // Entry width and default list capacity
    localparam int DATA_W           = 32;
    localparam int CAPACITY_DEFAULT = 16;

    // Command codes
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_SEARCH     = 3'd4
    } cmd_t;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } state_t;

    // Per-cell control from the controller
    typedef struct packed {
        logic shift_en;
        logic load_en;
    } cell_ctrl_t;

endpackage

// ----- src/bl_cell.sv -----
module bl_cell (
    input  logic                       aclk,
    input  bl_pkg::cell_ctrl_t         ctrl,
    input  logic [bl_pkg::DATA_W-1:0]  load_data,
    input  logic [bl_pkg::DATA_W-1:0]  prev_data,
    output logic [bl_pkg::DATA_W-1:0]  data_out
);

    logic [bl_pkg::DATA_W-1:0] data_reg;
    logic [bl_pkg::DATA_W-1:0] data_next;

    // Direct write wins over a shift from the neighbor
    always_comb begin
        data_next = data_reg;
        if (ctrl.load_en) begin
            data_next = load_data;
        end else if (ctrl.shift_en) begin
            data_next = prev_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// ----- src/bounded_list_with_search_top.sv -----
// Bounded list of signed 32-bit values with push front, push back, remove
// last, clear and search commands.
//
// Input channel s_valid/s_ready carries s_cmd and s_value; result channel
// m_valid/m_ready carries m_status, m_found and m_count, one result per
// command. Entries live in a row of CAPACITY cells, logical position k in
// cell k. Push front shifts the whole row by one cell.
//
// Push, remove, clear and unknown codes: result registered in the cycle after
// the transfer; one command per cycle while the result side keeps up.
// Search: the row rotates once through all CAPACITY cells, comparing the
// last cell with the key each cycle; the result is then queued from the done
// state, and the next command is taken once the result is queued.
//
// A new command is taken while the previous result is being transferred;
// if m_ready stays low the result holds and s_ready stays low.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared and are never read before written.
module bounded_list_with_search_top #(
    parameter int CAPACITY = bl_pkg::CAPACITY_DEFAULT,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_cmd,
    input  logic signed [bl_pkg::DATA_W-1:0]  s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic                              m_found,
    output logic [CNT_W-1:0]                  m_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    bl_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          scan_reg, scan_next;
    logic [bl_pkg::DATA_W-1:0] key_reg, key_next;
    logic                      hit_reg, hit_next;
    logic                      m_valid_reg, m_valid_next;
    logic [1:0]                m_status_reg, m_status_next;
    logic                      m_found_reg, m_found_next;
    logic [CNT_W-1:0]          m_count_reg, m_count_next;

    logic                      accept;
    logic                      out_free;
    logic                      full;
    logic                      push_front;
    logic                      push_back;
    logic                      rotate;
    logic [bl_pkg::DATA_W-1:0] head_in;
    logic [bl_pkg::DATA_W-1:0] cell_data [CAPACITY];

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == bl_pkg::S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));

    assign push_front = accept && (s_cmd == bl_pkg::CMD_PUSH_FRONT) && !full;
    assign push_back  = accept && (s_cmd == bl_pkg::CMD_PUSH_BACK) && !full;
    assign rotate     = (state_reg == bl_pkg::S_SEARCH);

    // Head of the chain: new value on push front, wrap-around during search
    assign head_in = rotate ? cell_data[CAPACITY-1] : s_value;

    // Row of cells
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        bl_pkg::cell_ctrl_t ctrl;
        assign ctrl.shift_en = push_front || rotate;
        assign ctrl.load_en  = push_back && (count_reg == CNT_W'(k));
        bl_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .load_data (s_value),
            .prev_data ((k == 0) ? head_in : cell_data[(k == 0) ? 0 : k - 1]),
            .data_out  (cell_data[k])
        );
    end

    // Command decode, search sequencing and result register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        key_next      = key_reg;
        hit_next      = hit_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_count_next  = m_count_reg;

        unique case (state_reg)
            bl_pkg::S_IDLE: begin
                if (accept) begin
                    m_status_next = bl_pkg::STATUS_OK;
                    m_found_next  = 1'b0;
                    unique case (s_cmd) inside
                        bl_pkg::CMD_PUSH_FRONT, bl_pkg::CMD_PUSH_BACK: begin
                            if (full) begin
                                m_status_next = bl_pkg::STATUS_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bl_pkg::CMD_REMOVE: begin
                            if (count_reg == '0) begin
                                m_status_next = bl_pkg::STATUS_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bl_pkg::CMD_CLEAR: begin
                            count_next = '0;
                        end
                        bl_pkg::CMD_SEARCH: begin
                            key_next   = s_value;
                            hit_next   = 1'b0;
                            scan_next  = IDX_W'(CAPACITY - 1);
                            state_next = bl_pkg::S_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                    m_count_next = count_next;
                    m_valid_next = (s_cmd != bl_pkg::CMD_SEARCH);
                end
            end
            bl_pkg::S_SEARCH: begin
                // Last cell holds logical position scan_reg this cycle
                if ((cell_data[CAPACITY-1] == key_reg) &&
                    (CNT_W'(scan_reg) < count_reg)) begin
                    hit_next = 1'b1;
                end
                if (scan_reg == '0) begin
                    state_next = bl_pkg::S_DONE;
                end else begin
                    scan_next = scan_reg - 1'b1;
                end
            end
            bl_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = bl_pkg::STATUS_OK;
                    m_found_next  = hit_reg;
                    m_count_next  = count_reg;
                    state_next    = bl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bl_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg     <= scan_next;
        key_reg      <= key_next;
        hit_reg      <= hit_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_found  = m_found_reg;
    assign m_count  = m_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_search_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == bl_pkg::CMD_SEARCH)) |=> (state_reg == bl_pkg::S_SEARCH))
        else $error("search did not start");

    a_search_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bl_pkg::S_SEARCH) |=> $stable(count_reg))
        else $error("count changed during search");

    a_found_only_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd != bl_pkg::CMD_SEARCH)) |=> (m_valid && !m_found))
        else $error("non-search result missing or flagged found");

endmodule
